// ===== rtl/cdes_pkg.sv =====
// shared types, constants and month table for the date to epoch seconds pipeline
`timescale 1ns / 1ps
`default_nettype none
package cdes_pkg;

	localparam int unsigned HourW   = 5;
	localparam int unsigned MinW    = 6;
	localparam int unsigned SecW    = 6;
	localparam int unsigned DayW    = 5;
	localparam int unsigned MonthW  = 4;
	localparam int unsigned YearW   = 14;
	localparam int unsigned EpochW  = 38;

	localparam int unsigned Q4W     = YearW - 2;   // year / 4
	localparam int unsigned Q16W    = YearW - 4;   // year / 16
	localparam int unsigned RecipW  = 12;          // reciprocal of 25, scaled by 2^16
	localparam int unsigned ProdW   = Q4W + RecipW;
	localparam int unsigned RecipSh = 16;
	localparam int unsigned QuotW   = ProdW - RecipSh;
	localparam int unsigned HmsW    = 17;
	localparam int unsigned MdayW   = 9;
	localparam int unsigned YdaysW  = 23;
	localparam int unsigned DaysW   = 23;
	localparam int unsigned SecDayW = 17;

	localparam logic [RecipW-1:0]  Recip25     = 12'd2622;
	localparam logic [YearW-1:0]   EpochYear   = 14'd1970;
	localparam logic [MonthW-1:0]  LastMonth   = 4'd12;
	localparam logic [MonthW-1:0]  February    = 4'd2;
	localparam logic [YdaysW-1:0]  LeapsBefore = 23'd477; // leap years in 1..1969
	localparam logic [SecDayW-1:0] SecsPerDay  = 17'd86400;

	// days before the first of a month, common year; month 0 acts as january
	function automatic logic [MdayW-1:0] days_before(input logic [MonthW-1:0] m);
		logic [MdayW-1:0] d;
		unique case (m)
			4'd0, 4'd1: d = 9'd0;
			4'd2:       d = 9'd31;
			4'd3:       d = 9'd59;
			4'd4:       d = 9'd90;
			4'd5:       d = 9'd120;
			4'd6:       d = 9'd151;
			4'd7:       d = 9'd181;
			4'd8:       d = 9'd212;
			4'd9:       d = 9'd243;
			4'd10:      d = 9'd273;
			4'd11:      d = 9'd304;
			default:    d = 9'd334;
		endcase
		return d;
	endfunction

	typedef struct packed {
		logic [HmsW-1:0]   hms;
		logic [DayW-1:0]   day_off;
		logic [MonthW-1:0] month;
		logic [YearW-1:0]  year;
		logic [ProdW-1:0]  p_prev100;
		logic [ProdW-1:0]  p_prev400;
		logic [ProdW-1:0]  p_year100;
		logic [ProdW-1:0]  p_year400;
	} cdes_div_t;

	typedef struct packed {
		logic [DaysW-1:0] days;
		logic [HmsW-1:0]  hms;
	} cdes_days_t;

endpackage
`default_nettype wire

// ===== rtl/cdes_if.sv =====
// valid/ready channel interfaces for calendar words and epoch words
`timescale 1ns / 1ps
`default_nettype none
interface cdes_date_if;
	logic        valid;
	logic        ready;
	logic [4:0]  hour_value;
	logic [5:0]  minute_value;
	logic [5:0]  second_value;
	logic [4:0]  day_of_month;
	logic [3:0]  month_number;
	logic [13:0] full_year;

	modport source (output valid, hour_value, minute_value, second_value, day_of_month,
		month_number, full_year, input ready);
	modport sink (input valid, hour_value, minute_value, second_value, day_of_month,
		month_number, full_year, output ready);
endinterface

interface cdes_epoch_if;
	logic        valid;
	logic        ready;
	logic [37:0] epoch_seconds;

	modport source (output valid, epoch_seconds, input ready);
	modport sink (input valid, epoch_seconds, output ready);
endinterface
`default_nettype wire

// ===== rtl/cdes_div_stage.sv =====
// stage 1: field clamping, time-of-day seconds and reciprocal products for /100 and /400
`timescale 1ns / 1ps
`default_nettype none
module cdes_div_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	cdes_date_if.sink               cal,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cdes_pkg::cdes_div_t     out_data
);
	import cdes_pkg::*;

	logic             adv;
	logic             valid_s1;
	cdes_div_t        data_s1;
	cdes_div_t        nxt;
	logic [YearW-1:0] prev_year;

	assign adv       = !valid_s1 || out_ready;
	assign cal.ready = adv;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_comb begin
		prev_year   = cal.full_year - YearW'(1);
		nxt.hms     = HmsW'(cal.hour_value) * HmsW'(3600) + HmsW'(cal.minute_value) * HmsW'(60)
			+ HmsW'(cal.second_value);
		// day zero counts as day one
		nxt.day_off = (cal.day_of_month == '0) ? '0 : cal.day_of_month - DayW'(1);
		nxt.month   = (cal.month_number > LastMonth) ? LastMonth : cal.month_number;
		nxt.year    = cal.full_year;
		// n/100 = (n/4)/25, n/400 = (n/16)/25, /25 by multiply with 2622 >> 16
		nxt.p_prev100 = ProdW'(prev_year[YearW-1:2]) * ProdW'(Recip25);
		nxt.p_prev400 = ProdW'(prev_year[YearW-1:4]) * ProdW'(Recip25);
		nxt.p_year100 = ProdW'(cal.full_year[YearW-1:2]) * ProdW'(Recip25);
		nxt.p_year400 = ProdW'(cal.full_year[YearW-1:4]) * ProdW'(Recip25);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cal.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cal.valid) begin
			data_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cdes_count_stage.sv =====
// stages 2 and 3: leap test, leap count, year and month days, total day count
`timescale 1ns / 1ps
`default_nettype none
module cdes_count_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cdes_pkg::cdes_div_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cdes_pkg::cdes_days_t    out_data
);
	import cdes_pkg::*;

	logic              adv2, adv3;
	logic              valid_s2, valid_s3;
	logic              after_s2;
	logic [YdaysW-1:0] ydays_s2;
	logic [Q4W-1:0]    leaps_s2;
	logic [MdayW-1:0]  mday_s2;
	logic [HmsW-1:0]   hms_s2;
	cdes_days_t        data_s3;

	logic [YearW-1:0]  prev_year;
	logic [QuotW-1:0]  dn100, dn400, dy100, dy400;
	logic              div100, div400, leap;
	logic              after;
	logic [YearW-1:0]  yoff;
	logic [Q4W-1:0]    leaps;
	logic [MdayW-1:0]  mday;
	logic [DaysW-1:0]  days;

	assign adv3      = !valid_s3 || out_ready;
	assign adv2      = !valid_s2 || adv3;
	assign in_ready  = adv2;
	assign out_valid = valid_s3;
	assign out_data  = data_s3;

	always_comb begin
		prev_year = in_data.year - YearW'(1);
		dn100 = in_data.p_prev100[ProdW-1:RecipSh];
		dn400 = in_data.p_prev400[ProdW-1:RecipSh];
		dy100 = in_data.p_year100[ProdW-1:RecipSh];
		dy400 = in_data.p_year400[ProdW-1:RecipSh];
		// with year divisible by 4, year%100 == 0 iff (year/4)%25 == 0
		div100 = in_data.year[Q4W+1:2] == Q4W'(dy100) * Q4W'(25);
		div400 = (in_data.year[3:0] == 4'd0) && (in_data.year[YearW-1:4] == Q16W'(dy400) * Q16W'(25));
		leap   = (in_data.year[1:0] == 2'd0) && (!div100 || div400);
		after  = in_data.year > EpochYear;
		yoff   = after ? in_data.year - EpochYear : '0;
		// leap years in 1..year-1
		leaps  = prev_year[YearW-1:2] - Q4W'(dn100) + Q4W'(dn400);
		mday   = days_before(in_data.month) + MdayW'(in_data.day_off)
			+ MdayW'(leap && (in_data.month > February));
	end

	always_comb begin
		days = DaysW'(mday_s2);
		if (after_s2) begin
			days = days + ydays_s2 + DaysW'(leaps_s2) - LeapsBefore;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= in_valid;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && in_valid) begin
			after_s2 <= after;
			ydays_s2 <= YdaysW'(yoff) * YdaysW'(365);
			leaps_s2 <= leaps;
			mday_s2  <= mday;
			hms_s2   <= in_data.hms;
		end
		if (adv3 && valid_s2) begin
			data_s3.days <= days;
			data_s3.hms  <= hms_s2;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cdes_scale_stage.sv =====
// stages 4 and 5: days to seconds and final sum into the output register
`timescale 1ns / 1ps
`default_nettype none
module cdes_scale_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cdes_pkg::cdes_days_t in_data,
	cdes_epoch_if.source            epoch
);
	import cdes_pkg::*;

	logic              adv4, adv5;
	logic              valid_s4, valid_s5;
	logic [EpochW-1:0] dsec_s4;
	logic [HmsW-1:0]   hms_s4;
	logic [EpochW-1:0] epoch_s5;

	assign adv5                = !valid_s5 || epoch.ready;
	assign adv4                = !valid_s4 || adv5;
	assign in_ready            = adv4;
	assign epoch.valid         = valid_s5;
	assign epoch.epoch_seconds = epoch_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv4) begin
				valid_s4 <= in_valid;
			end
			if (adv5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// product wraps to the output width
	always_ff @(posedge clk) begin
		if (adv4 && in_valid) begin
			dsec_s4 <= EpochW'(in_data.days) * EpochW'(SecsPerDay);
			hms_s4  <= in_data.hms;
		end
		if (adv5 && valid_s4) begin
			epoch_s5 <= dsec_s4 + EpochW'(hms_s4);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/calendar_date_to_epoch_seconds.sv =====
// five pipeline registers, each with its own valid bit, lie between input and output
// throughput: one word per cycle while the output is not stalled
// back-pressure: a stage advances when it is empty or the next one takes its word
// reset: arst_n clears all valid bits at once; payload registers are not reset
// top level: calendar date and time to seconds since 1970-01-01 00:00:00
`timescale 1ns / 1ps
`default_nettype none
module calendar_date_to_epoch_seconds (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cdes_date_if.sink    cal,
	cdes_epoch_if.source epoch
);
	import cdes_pkg::*;

	logic       div_valid, div_ready;
	cdes_div_t  div_data;
	logic       cnt_valid, cnt_ready;
	cdes_days_t cnt_data;

	cdes_div_stage u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	cdes_count_stage u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_data   (div_data),
		.out_valid (cnt_valid),
		.out_ready (cnt_ready),
		.out_data  (cnt_data)
	);

	cdes_scale_stage u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cnt_valid),
		.in_ready (cnt_ready),
		.in_data  (cnt_data),
		.epoch    (epoch)
	);

endmodule
`default_nettype wire
